// ===== rtl/core/sjis_to_iso2022_jp_encoder_unit_defines.svh =====
// Assertion macros shared by the encoder RTL.
// No dependencies; include by bare file name.
`ifndef SJIS_TO_ISO2022_JP_ENCODER_UNIT_DEFINES_SVH
`define SJIS_TO_ISO2022_JP_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define S2J_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("s2j assertion failed");

// Next-cycle implication, disabled in reset.
`define S2J_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("s2j assertion failed");

`endif

// ===== rtl/core/s2j_pkg.sv =====
// Constants, types and helper functions for the Shift-JIS to ISO-2022-JP encoder.
// No dependencies.
package s2j_pkg;

    localparam int SEQ_MAX = 4;
    localparam int SEQ_W   = $clog2(SEQ_MAX + 1);
    localparam int OUT_MAX = 2 * SEQ_MAX + 2;
    localparam int CNT_W   = $clog2(OUT_MAX + 1);

    localparam int ADDR_W  = 4;

    typedef enum logic [1:0] {
        REG_ENTER_BYTES = 2'd0,
        REG_ENTER_LEN   = 2'd1,
        REG_EXIT_BYTES  = 2'd2,
        REG_EXIT_LEN    = 2'd3
    } t_reg_idx;

    localparam logic [31:0] ENTER_BYTES_RST = 32'h0042_241B;
    localparam logic [2:0]  ENTER_LEN_RST   = 3'd3;
    localparam logic [31:0] EXIT_BYTES_RST  = 32'h0042_281B;
    localparam logic [2:0]  EXIT_LEN_RST    = 3'd3;

    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [SEQ_W-1:0] t_seq_len;

    function automatic logic is_lead(input logic [7:0] b);
        return (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hEF);
    endfunction

    function automatic logic is_trail(input logic [7:0] b);
        return (b >= 8'h40 && b <= 8'h7E) || (b >= 8'h80 && b <= 8'hFC);
    endfunction

    // Escape length, clipped to the longest burst the block supports.
    function automatic t_seq_len sat_len(input logic [2:0] len);
        if (int'(len) > SEQ_MAX) begin
            return SEQ_W'(SEQ_MAX);
        end
        return SEQ_W'(len);
    endfunction

    // Byte k of an escape word; bytes past the fourth read as zero.
    function automatic logic [7:0] seq_byte(input logic [31:0] bytes, input t_cnt k);
        if (int'(k) < 4) begin
            return bytes[{k[1:0], 3'b000} +: 8];
        end
        return 8'h00;
    endfunction

    // Shift-JIS pair to JIS pair, all arithmetic mod 256.
    function automatic logic [15:0] sjis_to_jis(input logic [7:0] lead,
                                                input logic [7:0] trail);
        logic [7:0] a;
        logic [7:0] t;
        a = lead;
        t = trail;
        if (a >= 8'hE0) a = a - 8'h40;
        if (t >= 8'h80) t = t - 8'h01;
        if (t >= 8'h9E) begin
            a = {a[6:0] - 7'h70, 1'b0};
            t = t - 8'h7D;
        end else begin
            a = {a[6:0] - 7'h70, 1'b0} - 8'h01;
            t = t - 8'h1F;
        end
        return {a, t};
    endfunction

endpackage

// ===== rtl/core/s2j_if.sv =====
// Valid/ready item channels for the encoder input and output.
// Does not depend on s2j_pkg; the channels use plain logic only.
interface s2j_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface s2j_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_end;

    modport source (output valid, output out_byte, output run_last, output stream_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input stream_end,
                    output ready);
endinterface

// ===== rtl/core/sjis_to_iso2022_jp_encoder_unit.sv =====
// Shift-JIS to ISO-2022-JP stream encoder, top level.
// Depends on s2j_pkg, s2j_if.sv and sjis_to_iso2022_jp_encoder_unit_defines.svh.
//
//  Channel  | Dir | Handshake        | Payload
//  ---------+-----+------------------+--------------------------------------
//  i_in     | in  | valid/ready      | in_byte[7:0], last_byte
//  o_out    | out | valid/ready      | out_byte[7:0], run_last, stream_end
//  APB      | in  | psel/penable     | paddr[3:0], pwdata[31:0], prdata[31:0]
//
// Flow: an item waits in the input register, then its burst of
// 0..2*SEQ_MAX+2 bytes leaves from the burst register at one byte per cycle.
// While o_out.ready holds high, plain bytes sustain one item per cycle;
// escape bytes lengthen the burst. The burst register is the throughput
// limit: the next burst loads on the edge the last byte of the current one is taken.
// Reset (synchronous, active low) clears stream state and restores the
// default escapes. An output stall holds the burst; one more item waits in
// the input register, then i_in.ready drops.
`include "sjis_to_iso2022_jp_encoder_unit_defines.svh"

module sjis_to_iso2022_jp_encoder_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    s2j_in_if.sink                    i_in,
    s2j_out_if.source                 o_out,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [s2j_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import s2j_pkg::*;

    // ---------------- configuration registers ----------------
    logic [31:0] r_enter_bytes;
    logic [2:0]  r_enter_len;
    logic [31:0] r_exit_bytes;
    logic [2:0]  r_exit_len;
    t_reg_idx    w_reg;
    logic        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_reg    = t_reg_idx'(paddr[3:2]);
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enter_bytes <= ENTER_BYTES_RST;
            r_enter_len   <= ENTER_LEN_RST;
            r_exit_bytes  <= EXIT_BYTES_RST;
            r_exit_len    <= EXIT_LEN_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg)
                REG_ENTER_BYTES: r_enter_bytes <= pwdata;
                REG_ENTER_LEN:   r_enter_len   <= pwdata[2:0];
                REG_EXIT_BYTES:  r_exit_bytes  <= pwdata;
                REG_EXIT_LEN:    r_exit_len    <= pwdata[2:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_ENTER_BYTES: prdata = r_enter_bytes;
            REG_ENTER_LEN:   prdata = {29'd0, r_enter_len};
            REG_EXIT_BYTES:  prdata = r_exit_bytes;
            REG_EXIT_LEN:    prdata = {29'd0, r_exit_len};
        endcase
    end

    // ---------------- input register ----------------
    logic       r_iv;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // ---------------- stream state ----------------
    logic       r_held_valid;
    logic [7:0] r_held_byte;
    logic       r_mode;          // 1: inside a double-byte run

    // ---------------- burst register ----------------
    // A burst is: prefix escape, up to two data bytes, suffix escape.
    logic        r_bv;
    t_cnt        r_pos;
    t_cnt        r_total;
    logic [31:0] r_pre_bytes;
    t_seq_len    r_pre_len;
    logic [7:0]  r_d0;
    logic [7:0]  r_d1;
    logic [1:0]  r_nd;
    t_seq_len    r_post_len;
    logic [31:0] r_post_bytes;
    logic        r_last;

    // next-burst descriptor and next state, from the input register
    logic [31:0] n_pre_bytes;
    t_seq_len    n_pre_len;
    logic [7:0]  n_d0;
    logic [7:0]  n_d1;
    logic [1:0]  n_nd;
    t_seq_len    n_post_len;
    t_cnt        n_total;
    logic        n_held_valid;
    logic [7:0]  n_held_byte;
    logic        n_mode;
    logic        w_pair;
    logic [15:0] w_jis;

    assign w_pair = r_held_valid && is_lead(r_held_byte) && is_trail(r_in_byte);
    assign w_jis  = sjis_to_jis(r_held_byte, r_in_byte);

    always_comb begin
        n_pre_bytes  = r_enter_bytes;
        n_pre_len    = '0;
        n_d0         = r_held_byte;
        n_d1         = r_in_byte;
        n_nd         = 2'd0;
        n_post_len   = '0;
        n_held_valid = r_held_valid;
        n_held_byte  = r_held_byte;
        n_mode       = r_mode;

        if (r_held_valid) begin
            if (w_pair) begin
                if (!r_mode) begin
                    n_pre_bytes = r_enter_bytes;
                    n_pre_len   = sat_len(r_enter_len);
                end
                n_d0         = w_jis[15:8];
                n_d1         = w_jis[7:0];
                n_nd         = 2'd2;
                n_mode       = 1'b1;
                n_held_valid = 1'b0;
            end else begin
                if (r_mode) begin
                    n_pre_bytes = r_exit_bytes;
                    n_pre_len   = sat_len(r_exit_len);
                end
                n_d0        = r_held_byte;
                n_nd        = 2'd1;
                n_mode      = 1'b0;
                n_held_byte = r_in_byte;
            end
        end else begin
            n_held_valid = 1'b1;
            n_held_byte  = r_in_byte;
        end

        if (r_in_last) begin
            // flush the pending byte, leaving a pair run first
            if (n_held_valid) begin
                if (n_mode) begin
                    n_pre_bytes = r_exit_bytes;
                    n_pre_len   = sat_len(r_exit_len);
                    n_mode      = 1'b0;
                end
                if (n_nd == 2'd0) begin
                    n_d0 = n_held_byte;
                end else begin
                    n_d1 = n_held_byte;
                end
                n_nd = n_nd + 2'd1;
            end
            // stream ended inside a pair run
            if (n_mode) begin
                n_post_len = sat_len(r_exit_len);
            end
            n_held_valid = 1'b0;
            n_mode       = 1'b0;
            n_held_byte  = 8'h00;
        end

        n_total = CNT_W'(n_pre_len) + CNT_W'(n_nd) + CNT_W'(n_post_len);
    end

    // ---------------- handshakes ----------------
    logic w_out_acc;
    logic w_run_last;
    logic w_burst_free;
    logic w_move;

    assign w_run_last   = (r_pos == r_total - t_cnt'(1));
    assign w_out_acc    = r_bv && o_out.ready;
    assign w_burst_free = !r_bv || (w_out_acc && w_run_last);
    // an item with no bytes only updates the stream state
    assign w_move       = r_iv && ((n_total == '0) || w_burst_free);
    assign i_in.ready   = !r_iv || w_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv         <= 1'b0;
            r_held_valid <= 1'b0;
            r_held_byte  <= 8'h00;
            r_mode       <= 1'b0;
            r_bv         <= 1'b0;
            r_pos        <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_iv      <= 1'b1;
                r_in_byte <= i_in.in_byte;
                r_in_last <= i_in.last_byte;
            end else if (w_move) begin
                r_iv <= 1'b0;
            end

            if (w_move) begin
                r_held_valid <= n_held_valid;
                r_held_byte  <= n_held_byte;
                r_mode       <= n_mode;
            end

            if (w_move && (n_total != '0)) begin
                r_bv         <= 1'b1;
                r_pos        <= '0;
                r_total      <= n_total;
                r_pre_bytes  <= n_pre_bytes;
                r_pre_len    <= n_pre_len;
                r_d0         <= n_d0;
                r_d1         <= n_d1;
                r_nd         <= n_nd;
                r_post_len   <= n_post_len;
                r_post_bytes <= r_exit_bytes;
                r_last       <= r_in_last;
            end else if (w_out_acc) begin
                if (w_run_last) begin
                    r_bv <= 1'b0;
                end else begin
                    r_pos <= r_pos + t_cnt'(1);
                end
            end
        end
    end

    // ---------------- output byte select ----------------
    t_cnt w_l0;
    t_cnt w_l01;
    t_cnt w_k;

    assign w_l0  = CNT_W'(r_pre_len);
    assign w_l01 = w_l0 + CNT_W'(r_nd);

    always_comb begin
        w_k = '0;
        if (r_pos < w_l0) begin
            w_k            = r_pos;
            o_out.out_byte = seq_byte(r_pre_bytes, w_k);
        end else if (r_pos < w_l01) begin
            w_k            = r_pos - w_l0;
            o_out.out_byte = (w_k == '0) ? r_d0 : r_d1;
        end else begin
            w_k            = r_pos - w_l01;
            o_out.out_byte = seq_byte(r_post_bytes, w_k);
        end
    end

    assign o_out.valid      = r_bv;
    assign o_out.run_last   = w_run_last;
    assign o_out.stream_end = w_run_last && r_last;

    // ---------------- assertions ----------------
    `S2J_ASSERT_NEXT(a_end_clears_state, i_clk, i_rst_n,
        w_move && r_in_last, !r_held_valid && !r_mode)
    `S2J_ASSERT_NOW(a_pos_in_burst, i_clk, i_rst_n,
        r_bv, (r_pos < r_total) && (r_total <= t_cnt'(OUT_MAX)))
    `S2J_ASSERT_NOW(a_end_is_run_last, i_clk, i_rst_n,
        o_out.valid && o_out.stream_end, o_out.run_last)
    `S2J_ASSERT_NEXT(a_wait_holds_item, i_clk, i_rst_n,
        r_iv && !w_move, r_iv && $stable(r_in_byte) && $stable(r_in_last))

endmodule

// ===== tb/sv/sjis_to_iso2022_jp_encoder_unit_test.sv =====
// Self-checking testbench for the Shift-JIS to ISO-2022-JP stream encoder.
// Needs s2j_pkg, the s2j_in_if/s2j_out_if channels and the encoder top level.
// Random valid/ready timing on both channels; escapes reprogrammed over APB between phases.
`timescale 1ns / 100ps

module sjis_to_iso2022_jp_encoder_unit_test;

    import s2j_pkg::*;

    // Run bounds
    localparam int CYCLE_LIMIT      = 500000;
    localparam int LONG_HOLD_CYCLES = 120;   // receiver back-pressure burst
    localparam int IDLE_TAIL        = 8;     // covers an item still in the input register

    // One converted output byte as seen on o_out
    typedef struct packed {
        logic [7:0] code;
        logic       item_end;
        logic       stream_done;
    } t_jis_out;

    // Tracks the encoder state, predicts the bytes each accepted item must produce and
    // compares them in order against what leaves the block.
    class t_jis_encode_board;
        logic [31:0] enter_word;
        logic [2:0]  enter_cnt;
        logic [31:0] exit_word;
        logic [2:0]  exit_cnt;
        logic [7:0]  held;
        bit          have_held;
        bit          in_pair_run;
        t_jis_out    burst[$];
        t_jis_out    pending_jis_bytes[$];
        int          mismatches;

        function new();
            enter_word  = ENTER_BYTES_RST;
            enter_cnt   = ENTER_LEN_RST;
            exit_word   = EXIT_BYTES_RST;
            exit_cnt    = EXIT_LEN_RST;
            held        = 8'h00;
            have_held   = 1'b0;
            in_pair_run = 1'b0;
            mismatches  = 0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [31:0] value);
            case (idx)
                REG_ENTER_BYTES: enter_word = value;
                REG_ENTER_LEN:   enter_cnt  = value[2:0];
                REG_EXIT_BYTES:  exit_word  = value;
                REG_EXIT_LEN:    exit_cnt   = value[2:0];
                default: ;
            endcase
        endfunction

        function bit lead_code(logic [7:0] b);
            if (b >= 8'h81 && b <= 8'h9F) return 1'b1;
            return b >= 8'hE0 && b <= 8'hEF;
        endfunction

        function bit trail_code(logic [7:0] b);
            if (b < 8'h40 || b == 8'h7F) return 1'b0;
            return b <= 8'hFC;
        endfunction

        function void push_code(logic [7:0] b);
            t_jis_out r;
            r.code        = b;
            r.item_end    = 1'b0;
            r.stream_done = 1'b0;
            burst.push_back(r);
        endfunction

        // Escape burst; length clipped to SEQ_MAX, bytes past the word read as zero
        function void push_escape(logic [31:0] word, logic [2:0] cnt);
            int n;
            n = (int'(cnt) > SEQ_MAX) ? SEQ_MAX : int'(cnt);
            for (int k = 0; k < n; k++) begin
                push_code(k < 4 ? word[8*k +: 8] : 8'h00);
            end
        endfunction

        function void push_single(logic [7:0] b);
            if (in_pair_run) begin
                push_escape(exit_word, exit_cnt);
                in_pair_run = 1'b0;
            end
            push_code(b);
        endfunction

        function void push_pair(logic [7:0] lead, logic [7:0] trail);
            logic [7:0] hi;
            logic [7:0] lo;
            if (!in_pair_run) begin
                push_escape(enter_word, enter_cnt);
                in_pair_run = 1'b1;
            end
            hi = lead;
            lo = trail;
            if (hi >= 8'hE0) hi = hi - 8'h40;
            if (lo >= 8'h80) lo = lo - 8'h01;
            hi = (hi - 8'h70) << 1;
            if (lo >= 8'h9E) begin
                lo = lo - 8'h7D;
            end else begin
                hi = hi - 8'h01;
                lo = lo - 8'h1F;
            end
            push_code(hi);
            push_code(lo);
        endfunction

        function void note_input(logic [7:0] b, logic last);
            t_jis_out tail;
            burst.delete();
            if (have_held) begin
                if (lead_code(held) && trail_code(b)) begin
                    push_pair(held, b);
                    have_held = 1'b0;
                end else begin
                    push_single(held);
                    held = b;
                end
            end else begin
                held      = b;
                have_held = 1'b1;
            end
            if (last) begin
                if (have_held) begin
                    push_single(held);
                    have_held = 1'b0;
                end
                if (in_pair_run) begin
                    push_escape(exit_word, exit_cnt);
                    in_pair_run = 1'b0;
                end
                held = 8'h00;
            end
            if (burst.size() > 0) begin
                tail             = burst.pop_back();
                tail.item_end    = 1'b1;
                tail.stream_done = last;
                burst.push_back(tail);
            end
            foreach (burst[i]) pending_jis_bytes.push_back(burst[i]);
        endfunction

        function void report(string what, logic [7:0] want, logic [7:0] got);
            mismatches++;
            $display("%0t: %s mismatch, expected %02h actual %02h", $time, what, want, got);
        endfunction

        function void check_result(logic [7:0] b, logic rl, logic se);
            t_jis_out want;
            if (pending_jis_bytes.size() == 0) begin
                report("unexpected out_byte", 8'h00, b);
                return;
            end
            want = pending_jis_bytes.pop_front();
            if (want.code !== b) report("out_byte", want.code, b);
            if (want.item_end !== rl) report("run_last", 8'(want.item_end), 8'(rl));
            if (want.stream_done !== se) report("stream_end", 8'(want.stream_done), 8'(se));
        endfunction

        function int pending();
            return pending_jis_bytes.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    s2j_in_if  in_ch ();
    s2j_out_if out_ch ();

    t_jis_encode_board board;

    int tx_max_gap   = 0;      // per-item idle draw for the sender
    int rx_max_stall = 0;      // per-item stall draw for the receiver
    bit rx_hold_req  = 1'b0;   // asks the receiver for one long hold-off
    int cycle_count  = 0;

    sjis_to_iso2022_jp_encoder_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sjis_to_iso2022_jp_encoder_unit verification failed");
            $finish;
        end
    end

    // Both channels sampled at the edge; inputs first so a queue is never read stale
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (in_ch.valid && in_ch.ready) begin
                board.note_input(in_ch.in_byte, in_ch.last_byte);
            end
            if (out_ch.valid && out_ch.ready) begin
                board.check_result(out_ch.out_byte, out_ch.run_last, out_ch.stream_end);
            end
        end
    end

    // Receiver: one stall draw per output byte, plus an occasional long hold-off
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end
            stall = $urandom_range(0, rx_max_stall);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // Called at a clock edge; returns at the edge the item is taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.in_byte   <= b;
        in_ch.last_byte <= last;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Stop offering and let every predicted byte come out, then a short tail
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (IDLE_TAIL) @(posedge i_clk);
    endtask

    // Setup then access; the return to idle keeps back-to-back writes clean
    task automatic apb_write(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.write_reg(idx, value);
        @(posedge i_clk);
    endtask

    task automatic program_escapes(input logic [31:0] enter_bytes, input logic [2:0] enter_len,
                                   input logic [31:0] exit_bytes, input logic [2:0] exit_len);
        apb_write(REG_ENTER_BYTES, enter_bytes);
        apb_write(REG_ENTER_LEN, 32'(enter_len));
        apb_write(REG_EXIT_BYTES, exit_bytes);
        apb_write(REG_EXIT_LEN, 32'(exit_len));
    endtask

    function automatic logic [7:0] pick_lead();
        if ($urandom_range(0, 1) == 0) return 8'(8'h81 + $urandom_range(0, 30));
        return 8'(8'hE0 + $urandom_range(0, 15));
    endfunction

    function automatic logic [7:0] pick_trail();
        int r;
        r = $urandom_range(0, 187);
        if (r < 63) return 8'(8'h40 + r);
        return 8'(8'h80 + r - 63);
    endfunction

    // Bytes that can never close a pair
    function automatic logic [7:0] pick_bad_trail();
        int r;
        r = $urandom_range(0, 67);
        if (r < 64) return 8'(r);
        if (r == 64) return 8'h7F;
        return 8'(8'hFD + r - 65);
    endfunction

    function automatic logic end_draw();
        return $urandom_range(0, 15) == 0;
    endfunction

    // Text-like stream: mostly well-formed pairs and ASCII, some broken pairs and noise
    task automatic send_random_text(input int n_items);
        int sent;
        int kind;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                send_byte(pick_lead(), end_draw());
                send_byte(pick_trail(), end_draw());
                sent += 2;
            end else if (kind < 78) begin
                send_byte(8'($urandom_range(0, 127)), end_draw());
                sent += 1;
            end else if (kind < 88) begin
                send_byte(pick_lead(), 1'b0);
                send_byte(pick_bad_trail(), end_draw());
                sent += 2;
            end else begin
                send_byte(8'($urandom_range(0, 255)), end_draw());
                sent += 1;
            end
        end
    endtask

    initial begin
        board = new();
        in_ch.valid     <= 1'b0;
        in_ch.in_byte   <= 8'h00;
        in_ch.last_byte <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= 32'h0;
        i_rst_n         <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset escapes, no idling on either side
        send_byte(8'h41, 1'b0);
        send_byte(8'h00, 1'b0);   // zero byte is plain data
        send_byte(8'h81, 1'b0);
        send_byte(8'h40, 1'b0);   // lowest pair, enters the pair run
        send_byte(8'h9F, 1'b0);
        send_byte(8'hFC, 1'b0);   // highest trail
        send_byte(8'hE0, 1'b0);
        send_byte(8'h9F, 1'b0);   // trail in the upper half of the row
        send_byte(8'hEF, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'h7F, 1'b0);   // not a trail: lead leaves the run as a plain byte
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFD, 1'b1);
        send_byte(8'h88, 1'b0);
        send_byte(8'hA0, 1'b1);   // stream ends inside a pair run
        send_byte(8'h30, 1'b1);   // one-byte stream
        send_byte(8'h82, 1'b1);   // stream ends on a lone lead
        send_byte(8'h80, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'hFC, 1'b1);
        send_byte(8'hE5, 1'b0);
        send_byte(8'h80, 1'b0);   // trail just above the gap
        send_byte(8'hE5, 1'b1);
        wait_idle();

        // No escapes at all, full idling both sides
        program_escapes(32'h0000_0000, 3'd0, 32'hFFFF_FFFF, 3'd0);
        tx_max_gap   = 13;
        rx_max_stall = 13;
        send_random_text(40);
        wait_idle();

        // Longest escapes; long receiver hold-off while the sender keeps pushing
        program_escapes($urandom(), 3'd4, $urandom(), 3'd4);
        tx_max_gap   = 0;
        rx_max_stall = 13;
        send_random_text(25);
        rx_hold_req  = 1'b1;
        send_random_text(35);
        wait_idle();              // sender pauses until everything is out
        send_random_text(20);
        wait_idle();

        // Lengths past SEQ_MAX saturate; receiver never stalls
        program_escapes($urandom(), 3'd7, $urandom(), 3'd5);
        tx_max_gap   = 13;
        rx_max_stall = 0;
        send_random_text(50);
        wait_idle();

        // Short escapes built from the default words
        program_escapes(ENTER_BYTES_RST, 3'd1, EXIT_BYTES_RST, 3'd2);
        tx_max_gap   = 13;
        rx_max_stall = 13;
        send_random_text(40);
        wait_idle();

        // Arbitrary setting, sender at full rate
        program_escapes($urandom(), 3'($urandom_range(0, 7)), $urandom(),
                        3'($urandom_range(0, 7)));
        tx_max_gap   = 0;
        rx_max_stall = 5;
        send_random_text(30);
        wait_idle();

        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("sjis_to_iso2022_jp_encoder_unit verification clean");
        end else begin
            $display("sjis_to_iso2022_jp_encoder_unit verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/s2j_pkg.sv
rtl/core/s2j_if.sv
rtl/core/sjis_to_iso2022_jp_encoder_unit.sv
tb/sv/sjis_to_iso2022_jp_encoder_unit_test.sv
